FILE: rtl/ps2mpt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// types, codes and helpers shared by the ps/2 mouse packet tracker modules
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = COORD_BITS + 1;
    localparam int SUM_BITS   = COORD_BITS + 2;

    localparam logic [CFG_BITS-1:0] COORD_TOP    = CFG_BITS'(1) << COORD_BITS;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);
    localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(240);

    // header byte bits
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam logic [7:0] HDR_OVF = 8'hC0;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        MODE_BYTE      = 2'd0,
        MODE_CLR_EDGES = 2'd1,
        MODE_CLR_MOVED = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_PARTIAL  = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    typedef struct packed {
        logic       from_aux;
        logic [7:0] rx_byte;
        logic [1:0] mode;
    } t_item;

    typedef struct packed {
        t_status               packet_status;
        logic                  moved_flag;
        logic [2:0]            released_sticky;
        logic [2:0]            pressed_sticky;
        logic [2:0]            button_bits;
        logic signed [9:0]     last_dy;
        logic signed [8:0]     last_dx;
        logic [COORD_BITS-1:0] cursor_y;
        logic [COORD_BITS-1:0] cursor_x;
    } t_result;

    // zero is taken as one, anything past the coordinate range saturates
    function automatic logic [CFG_BITS-1:0] bound_limit(input logic [CFG_BITS-1:0] b);
        logic [CFG_BITS-1:0] lim;
        if (b == '0) begin
            lim = CFG_BITS'(1);
        end else if (b > COORD_TOP) begin
            lim = COORD_TOP;
        end else begin
            lim = b;
        end
        return lim;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_BITS-1:0] v,
        input logic [CFG_BITS-1:0]        lim
    );
        logic [CFG_BITS-1:0]   top;
        logic [COORD_BITS-1:0] r;
        top = lim - CFG_BITS'(1);
        if (v < 0) begin
            r = '0;
        end else if (v >= $signed({1'b0, lim})) begin
            r = top[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/ps2mpt_in_reg.sv
// ----------------------------------------------------------------------------
// ps2mpt_in_reg
// input register of the tracker, takes a beat whenever it is empty or draining
// ----------------------------------------------------------------------------
module ps2mpt_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ps2mpt_pkg::t_item    i_item,
    input  logic                 i_adv,
    output logic                 o_valid,
    output ps2mpt_pkg::t_item    o_item
);

    logic              r_valid;
    ps2mpt_pkg::t_item r_item;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: rtl/ps2mpt_core.sv
// ----------------------------------------------------------------------------
// ps2mpt_core
// packet assembly, delta decode, cursor clamp and sticky button state
// ----------------------------------------------------------------------------
module ps2mpt_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_addr,
    input  logic [ps2mpt_pkg::CFG_BITS-1:0]       i_cfg_wdata,
    input  logic                                  i_adv,
    input  ps2mpt_pkg::t_item                     i_item,
    output ps2mpt_pkg::t_result                   o_result
);

    localparam int CB = ps2mpt_pkg::COORD_BITS;
    localparam int SB = ps2mpt_pkg::SUM_BITS;

    logic [ps2mpt_pkg::CFG_BITS-1:0] r_width, r_height;

    logic [1:0]          r_count,   n_count;
    logic [7:0]          r_header,  n_header;
    logic [7:0]          r_xbyte,   n_xbyte;
    logic [CB-1:0]       r_pos_x,   n_pos_x;
    logic [CB-1:0]       r_pos_y,   n_pos_y;
    logic signed [8:0]   r_dx,      n_dx;
    logic signed [9:0]   r_dy,      n_dy;
    logic [2:0]          r_buttons, n_buttons;
    logic [2:0]          r_press,   n_press;
    logic [2:0]          r_release, n_release;
    logic                r_moved,   n_moved;

    ps2mpt_pkg::t_status status;

    logic signed [8:0]   dx;
    logic signed [8:0]   dy_raw;
    logic signed [9:0]   dy;
    logic signed [SB-1:0] sum_x, sum_y;
    logic [2:0]          new_btn, changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ps2mpt_pkg::WIDTH_RESET;
            r_height <= ps2mpt_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ps2mpt_pkg::CFG_WIDTH:  r_width  <= i_cfg_wdata;
                ps2mpt_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // packet decode, only used when the third byte lands
    always_comb begin
        dx      = $signed({r_header[ps2mpt_pkg::HDR_XSIGN_BIT], r_xbyte});
        dy_raw  = $signed({r_header[ps2mpt_pkg::HDR_YSIGN_BIT], i_item.rx_byte});
        dy      = -$signed({dy_raw[8], dy_raw});
        sum_x   = $signed({2'b00, r_pos_x}) + SB'(dx);
        sum_y   = $signed({2'b00, r_pos_y}) + SB'(dy);
        new_btn = r_header[2:0];
        changed = r_buttons ^ new_btn;
    end

    always_comb begin
        n_count   = r_count;
        n_header  = r_header;
        n_xbyte   = r_xbyte;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_buttons = r_buttons;
        n_press   = r_press;
        n_release = r_release;
        n_moved   = r_moved;
        status    = ps2mpt_pkg::ST_PARTIAL;

        case (i_item.mode)
            ps2mpt_pkg::MODE_BYTE: begin
                if (!i_item.from_aux) begin
                    status = ps2mpt_pkg::ST_IGNORED;
                end else begin
                    case (r_count)
                        2'd0: begin
                            // drop bytes until a header with the sync bit shows up
                            if (i_item.rx_byte[ps2mpt_pkg::HDR_SYNC_BIT]) begin
                                n_header = i_item.rx_byte;
                                n_count  = 2'd1;
                            end
                        end
                        2'd1: begin
                            n_xbyte = i_item.rx_byte;
                            n_count = 2'd2;
                        end
                        default: begin
                            n_count = 2'd0;
                            if ((r_header & ps2mpt_pkg::HDR_OVF) != 8'h00) begin
                                status = ps2mpt_pkg::ST_OVERFLOW;
                            end else begin
                                status    = ps2mpt_pkg::ST_ACCEPTED;
                                n_dx      = dx;
                                n_dy      = dy;
                                n_pos_x   = ps2mpt_pkg::clamp_coord(sum_x,
                                                ps2mpt_pkg::bound_limit(r_width));
                                n_pos_y   = ps2mpt_pkg::clamp_coord(sum_y,
                                                ps2mpt_pkg::bound_limit(r_height));
                                n_buttons = new_btn;
                                n_press   = r_press | (changed & new_btn);
                                n_release = r_release | (changed & r_buttons);
                                if (dx != 0 || dy != 0 || changed != 3'b000) begin
                                    n_moved = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ps2mpt_pkg::MODE_CLR_EDGES: begin
                n_press   = 3'b000;
                n_release = 3'b000;
            end
            ps2mpt_pkg::MODE_CLR_MOVED: begin
                n_moved = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 2'd0;
            r_header  <= 8'h00;
            r_xbyte   <= 8'h00;
            r_pos_x   <= ps2mpt_pkg::POS_X_RESET;
            r_pos_y   <= ps2mpt_pkg::POS_Y_RESET;
            r_dx      <= '0;
            r_dy      <= '0;
            r_buttons <= 3'b000;
            r_press   <= 3'b000;
            r_release <= 3'b000;
            r_moved   <= 1'b0;
        end else if (i_adv) begin
            r_count   <= n_count;
            r_header  <= n_header;
            r_xbyte   <= n_xbyte;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            r_buttons <= n_buttons;
            r_press   <= n_press;
            r_release <= n_release;
            r_moved   <= n_moved;
        end
    end

    // result shows the state after this beat
    always_comb begin
        o_result.cursor_x        = n_pos_x;
        o_result.cursor_y        = n_pos_y;
        o_result.last_dx         = n_dx;
        o_result.last_dy         = n_dy;
        o_result.button_bits     = n_buttons;
        o_result.pressed_sticky  = n_press;
        o_result.released_sticky = n_release;
        o_result.moved_flag      = n_moved;
        o_result.packet_status   = status;
    end

endmodule

FILE: rtl/ps2mpt_out_reg.sv
// ----------------------------------------------------------------------------
// ps2mpt_out_reg
// result register, holds a beat until the receiver takes it
// ----------------------------------------------------------------------------
module ps2mpt_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  ps2mpt_pkg::t_result   i_result,
    input  logic                  i_ready,
    output logic                  o_valid,
    output ps2mpt_pkg::t_result   o_result
);

    logic                r_valid;
    ps2mpt_pkg::t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/ps2_mouse_packet_tracker_unit.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// ps/2 mouse 3-byte packet tracker with clamped cursor and button state
// ----------------------------------------------------------------------------
// input stream: one beat per byte or command read from the controller; tuser
//   carries the mode (byte, clear button edges, clear moved flag) and the
//   aux-port flag, tdata the received byte.
// output stream: exactly one beat per input beat, holding the cursor, the
//   deltas of the last good packet, the buttons, the sticky edges, the moved
//   flag and, in tuser, the packet status of that byte.
// config port: index 0 screen width, index 1 screen height; write only while
//   no beats are in flight. a new bound takes effect with the next packet.
// path: an input beat passes the input register, then the result register.
//   throughput: one beat per cycle while m_axis_tready stays high, set by
//   the single decode and clamp stage between the two registers.
// reset (synchronous, active low): both registers empty, cursor at 320,240,
//   bounds 640x480, packet assembly restarts at the header byte.
// stall: the result register holds its beat while m_axis_tready is low; one
//   more beat waits in the input register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [2:0]  s_axis_tuser,   // [1:0] mode, [2] from_aux

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [32:24] last_dx, [42:33] last_dy,
    // [45:43] button_bits, [48:46] pressed_sticky, [51:49] released_sticky,
    // [52] moved_flag, [55:53] zero
    output logic [55:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // [1:0] packet_status
);

    ps2mpt_pkg::t_item   s_item, q_item;
    ps2mpt_pkg::t_result core_res, out_res;
    logic                q_valid;
    logic                adv;

    assign s_item.mode     = s_axis_tuser[1:0];
    assign s_item.from_aux = s_axis_tuser[2];
    assign s_item.rx_byte  = s_axis_tdata;

    assign adv = q_valid && (!m_axis_tvalid || m_axis_tready);

    ps2mpt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .i_adv   (adv),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    ps2mpt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_item      (q_item),
        .o_result    (core_res)
    );

    ps2mpt_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_result (core_res),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (out_res)
    );

    assign m_axis_tdata = {3'b000,
                           out_res.moved_flag,
                           out_res.released_sticky,
                           out_res.pressed_sticky,
                           out_res.button_bits,
                           out_res.last_dy,
                           out_res.last_dx,
                           out_res.cursor_y,
                           out_res.cursor_x};
    assign m_axis_tuser = out_res.packet_status;

endmodule

FILE: rtl/ps2mpt_checker.sv
// ----------------------------------------------------------------------------
// ps2mpt_checker
// port-level checks for the ps/2 mouse packet tracker
// ----------------------------------------------------------------------------
module ps2mpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("beats visible after reset");

    // input side only backs up when the result side is full and stalled
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // an accepted packet with motion must have set the moved flag
    a_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ps2mpt_pkg::ST_ACCEPTED && !m_axis_tdata[52]
        |-> m_axis_tdata[32:24] == 9'd0 && m_axis_tdata[42:33] == 10'd0)
        else $error("motion without moved flag");

endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker u_ps2mpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
